/* hw/rtl/epfog_pkg.sv */
// Shared types, constants and lookup functions for the equal-power fade-out gain block.
// Used by epfog_div, epfog_cos and equal_power_fade_out_gain_unit; no dependencies.
package epfog_pkg;

  localparam int unsigned PHASE_BITS_DEF = 10;
  localparam int unsigned FADE_W         = 16;
  localparam int unsigned POS_W          = 31;
  localparam int unsigned GAIN_W         = 15;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned NUM_TERMS      = 6;
  localparam int unsigned TERM_W         = 3;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] GAIN_ROUND  = 31'h0000_4000;

  typedef enum logic [OP_W-1:0] {
    OP_POSITION = 2'd0,
    OP_TICK     = 2'd1,
    OP_TRACK    = 2'd2,
    OP_DURATION = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_LENGTH = 1'd0,
    REG_ENABLED     = 1'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CURVE,
    ST_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ANGLE,
    CS_SQUARE,
    CS_HOLDX2,
    CS_SCALE,
    CS_RECIP,
    CS_BACK,
    CS_FIX
  } cos_state_e;

  // Handshake between the control FSM and the curve sequencer
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } cos_status_t;

  // Taylor denominators, highest order term first
  function automatic logic [7:0] term_divisor(input logic [TERM_W-1:0] term);
    logic [7:0] d;
    case (term)
      3'd0:    d = 8'd132;
      3'd1:    d = 8'd90;
      3'd2:    d = 8'd56;
      3'd3:    d = 8'd30;
      3'd4:    d = 8'd12;
      3'd5:    d = 8'd2;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor): estimate is low by at most one
  function automatic logic [31:0] term_recip(input logic [TERM_W-1:0] term);
    logic [31:0] r;
    case (term)
      3'd0:    r = 32'd32537631;
      3'd1:    r = 32'd47721858;
      3'd2:    r = 32'd76695844;
      3'd3:    r = 32'd143165576;
      3'd4:    r = 32'd357913941;
      3'd5:    r = 32'd2147483648;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/epfog_div.sv */
// Serial restoring divider: quotient of (into << PHASE_BITS) / divisor, one bit a cycle.
// Depends on epfog_pkg; requires into < divisor.
module epfog_div #(
  parameter int unsigned PHASE_BITS = epfog_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [epfog_pkg::FADE_W-1:0]  into_i,
  input  logic [epfog_pkg::FADE_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [PHASE_BITS-1:0]         quotient_o
);
  import epfog_pkg::*;

  localparam int unsigned CNT_W = $clog2(PHASE_BITS + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FADE_W-1:0] rem_q, rem_d;
  logic [PHASE_BITS-1:0] quo_q, quo_d;
  logic [FADE_W:0]   shifted;
  logic              ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(PHASE_BITS);
      rem_d  = into_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? FADE_W'(shifted - {1'b0, divisor_i}) : shifted[FADE_W-1:0];
      quo_d = {quo_q[PHASE_BITS-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/epfog_cos.sv */
// Quarter-cosine curve: nested Taylor terms on one shared 32x32 multiplier.
// Depends on epfog_pkg; constant division done by reciprocal multiply and correction.
module epfog_cos #(
  parameter int unsigned PHASE_BITS = epfog_pkg::PHASE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [PHASE_BITS-1:0]     idx_i,
  output epfog_pkg::cos_status_t    status_o
);
  import epfog_pkg::*;

  cos_state_e        state_q, state_d;
  logic [TERM_W-1:0] term_q;
  logic [PHASE_BITS-1:0] idx_q;
  logic [63:0]       prod_q;
  logic [31:0]       x2_q, y_q, q_q;
  logic [30:0]       t_q;
  logic              done_q;
  logic [31:0]       mul_a, mul_b;
  logic [31:0]       rem;
  logic [31:0]       p_fix;
  logic [30:0]       t_next;
  logic [30:0]       rounded;
  logic              last_term;

  assign last_term = term_q == TERM_W'(NUM_TERMS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE:   if (start_i) state_d = CS_ANGLE;
      CS_ANGLE:  state_d = CS_SQUARE;
      CS_SQUARE: state_d = CS_HOLDX2;
      CS_HOLDX2: state_d = CS_SCALE;
      CS_SCALE:  state_d = CS_RECIP;
      CS_RECIP:  state_d = CS_BACK;
      CS_BACK:   state_d = CS_FIX;
      CS_FIX:    state_d = last_term ? CS_IDLE : CS_SCALE;
      default:   state_d = CS_IDLE;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      CS_ANGLE: begin
        mul_a = HALF_PI_Q30;
        mul_b = 32'(idx_q);
      end
      CS_SQUARE: begin
        mul_a = {1'b0, prod_q[PHASE_BITS +: 31]};
        mul_b = {1'b0, prod_q[PHASE_BITS +: 31]};
      end
      CS_SCALE: begin
        mul_a = x2_q;
        mul_b = {1'b0, t_q};
      end
      CS_RECIP: begin
        mul_a = prod_q[61:30];
        mul_b = term_recip(term_q);
      end
      CS_BACK: begin
        mul_a = prod_q[63:32];
        mul_b = 32'(term_divisor(term_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Correct the low-by-one estimate, then form t = 1 - p clamped at zero
  assign rem    = y_q - prod_q[31:0];
  assign p_fix  = (rem >= 32'(term_divisor(term_q))) ? q_q + 32'd1 : q_q;
  assign t_next = (p_fix >= {1'b0, Q30_ONE}) ? '0 : Q30_ONE - p_fix[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      term_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CS_FIX) && last_term;
      if (state_q == CS_HOLDX2) begin
        term_q <= '0;
      end else if (state_q == CS_FIX) begin
        term_q <= term_q + TERM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == CS_IDLE && start_i) idx_q <= idx_i;
    if (state_q == CS_HOLDX2) begin
      x2_q <= prod_q[61:30];
      t_q  <= Q30_ONE;
    end
    if (state_q == CS_RECIP) y_q <= prod_q[61:30];
    if (state_q == CS_BACK)  q_q <= prod_q[63:32];
    if (state_q == CS_FIX)   t_q <= t_next;
  end

  assign rounded       = t_q + GAIN_ROUND;
  assign status_o.done = done_q;
  assign status_o.gain = rounded[30] ? {GAIN_W{1'b1}} : rounded[29:15];

endmodule

/* hw/rtl/equal_power_fade_out_gain_unit.sv */
// Equal-power fade-out gain: event handling, fade state and result register.
// Depends on epfog_pkg, epfog_div and epfog_cos.
// A tick inside the fade gives its result after the serial divider and the curve sequence
// (angle, square, then scale, reciprocal, back-multiply and fix per Taylor term) have run.
// The end-of-fade tick goes straight to the emit state and the result register; other transactions
// finish in their accept cycle. One transaction at a time. Reset: fade idle, enabled set.
module equal_power_fade_out_gain_unit #(
  parameter int unsigned PHASE_BITS = epfog_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [epfog_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [epfog_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // event channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [epfog_pkg::OP_W-1:0]        operation_i,
  input  logic [epfog_pkg::POS_W-1:0]       value_ms_i,
  // gain channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [epfog_pkg::GAIN_W-1:0]      gain_q15_o,
  output logic                              fade_end_o
);
  import epfog_pkg::*;

  top_state_e        state_q, state_d;

  // configuration registers
  logic [FADE_W-1:0] fade_len_q;
  logic              enabled_q;

  // playback tracking
  logic              fading_q;
  logic [POS_W-1:0]  last_pos_q;
  logic [POS_W-1:0]  start_pos_q;
  logic [POS_W-1:0]  track_len_q;

  // pending result and output register
  logic [GAIN_W-1:0] res_gain_q;
  logic              res_end_q;
  logic              out_valid_q;
  logic [GAIN_W-1:0] out_gain_q;
  logic              out_end_q;

  logic              accept;
  logic              tick_run;
  logic              tick_end;
  logic              arm;
  logic [POS_W-1:0]  into_full;
  logic [POS_W-1:0]  remaining;
  logic              div_start;
  logic              div_done;
  logic [PHASE_BITS-1:0] div_quo;
  cos_status_t       cos_status;
  logic              out_load;

  assign accept    = in_valid_i && in_ready_o;

  // into = last - start, floored at zero; it fits FADE_W bits whenever the fade continues
  assign into_full = (last_pos_q > start_pos_q) ? last_pos_q - start_pos_q : '0;
  assign tick_run  = enabled_q && (fade_len_q != '0) && fading_q
                     && (op_e'(operation_i) == OP_TICK);
  assign tick_end  = into_full >= POS_W'(fade_len_q);

  // Arm when not fading, fade and track lengths are nonzero and 0 < track - position <= fade length
  assign remaining = track_len_q - value_ms_i;
  assign arm = (fade_len_q != '0) && (track_len_q != '0) && !fading_q
               && (track_len_q > value_ms_i) && (remaining <= POS_W'(fade_len_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && tick_run) state_d = tick_end ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: if (div_done) state_d = ST_CURVE;
      ST_CURVE:  if (cos_status.done) state_d = ST_EMIT;
      ST_EMIT:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = accept && tick_run && !tick_end;
      end
      ST_EMIT:  out_load = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  epfog_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .into_i     (into_full[FADE_W-1:0]),
    .divisor_i  (fade_len_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  epfog_cos #(
    .PHASE_BITS (PHASE_BITS)
  ) u_cos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_done),
    .idx_i    (div_quo),
    .status_o (cos_status)
  );

  // Control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fade_len_q  <= '0;
      enabled_q   <= 1'b1;
      fading_q    <= 1'b0;
      last_pos_q  <= '0;
      start_pos_q <= '0;
      track_len_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Hold the result until taken; load it from the pending slot
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Drop every transaction while disabled
      if (accept && enabled_q) begin
        case (op_e'(operation_i))
          OP_POSITION: begin
            last_pos_q <= value_ms_i;
            if (arm) begin
              fading_q    <= 1'b1;
              start_pos_q <= value_ms_i;
            end
          end
          OP_TICK: begin
            if (tick_run && tick_end) fading_q <= 1'b0;
          end
          OP_TRACK: begin
            fading_q    <= 1'b0;
            last_pos_q  <= '0;
            track_len_q <= value_ms_i;
          end
          OP_DURATION: track_len_q <= value_ms_i;
          default: ;
        endcase
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_FADE_LENGTH: fade_len_q <= cfg_data_i[FADE_W-1:0];
          REG_ENABLED: begin
            enabled_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) fading_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && tick_run && tick_end) begin
      res_gain_q <= '0;
      res_end_q  <= 1'b1;
    end else if (cos_status.done) begin
      res_gain_q <= cos_status.gain;
      res_end_q  <= 1'b0;
    end
    if (out_load) begin
      out_gain_q <= res_gain_q;
      out_end_q  <= res_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gain_q15_o  = out_gain_q;
  assign fade_end_o  = out_end_q;

  // The divider reports only while the FSM waits on it
  a_div_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVIDE)
    else $error("divider done outside divide phase");

  // The curve sequencer reports only while the FSM waits on it
  a_cos_done_in_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cos_status.done |-> state_q == ST_CURVE)
    else $error("curve done outside curve phase");

  // A free output slot in the emit phase produces a result next cycle
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("result not presented after emit");

  // No new transaction while an item is in flight
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE || state_q == ST_CURVE) |-> !in_ready_o)
    else $error("input accepted during computation");

endmodule

/* tb/equal_power_fade_out_gain_checker.sv */
// Scoreboard for the equal-power fade-out gain unit: tracks register writes and accepted
// events, predicts each gain result and compares it with the result channel. Uses epfog_pkg.
`timescale 1ns / 100ps

module equal_power_fade_out_gain_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [epfog_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [epfog_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [epfog_pkg::OP_W-1:0]        operation_i,
  input  logic [epfog_pkg::POS_W-1:0]       value_ms_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [epfog_pkg::GAIN_W-1:0]      gain_q15_i,
  input  logic                              fade_end_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       gains_seen_o,
  output int unsigned                       fade_ends_seen_o
);
  import epfog_pkg::*;

  localparam int unsigned PHASE_BITS       = PHASE_BITS_DEF;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              fade_end;
  } gain_result_t;

  logic [FADE_W-1:0] fade_len_q;
  logic              enabled_q;
  logic              fading_q;
  logic [POS_W-1:0]  last_pos_q;
  logic [POS_W-1:0]  start_pos_q;
  logic [POS_W-1:0]  track_len_q;
  gain_result_t      gain_due_q[$];

  // Quarter cosine by a nested Taylor series; the denominators are (2m)(2m-1), m = 6..1.
  function automatic logic [GAIN_W-1:0] curve_gain(input logic [63:0] phase_idx);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] acc;
    logic [63:0] part;
    angle    = (QUARTER_TURN_Q30 * phase_idx) >> PHASE_BITS;
    angle_sq = (angle * angle) >> 30;
    acc      = UNIT_Q30;
    for (int m = 6; m >= 1; m--) begin
      part = ((angle_sq * acc) >> 30) / ((2 * m) * (2 * m - 1));
      acc  = (part >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - part;
    end
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) acc = 64'd32767;
    return acc[GAIN_W-1:0];
  endfunction

  function automatic void apply_event(input op_e op, input logic [POS_W-1:0] val);
    logic signed [63:0] remaining;
    logic [63:0]        into;
    gain_result_t       res;
    if (!enabled_q) return;
    case (op)
      OP_POSITION: begin
        last_pos_q = val;
        if (fade_len_q != 0 && track_len_q != 0 && !fading_q) begin
          remaining = $signed({33'b0, track_len_q}) - $signed({33'b0, val});
          if (remaining > 0 && remaining <= $signed({48'b0, fade_len_q})) begin
            fading_q    = 1'b1;
            start_pos_q = val;
          end
        end
      end
      OP_TICK: begin
        if (fade_len_q != 0 && fading_q) begin
          into = (last_pos_q > start_pos_q) ? {33'b0, last_pos_q - start_pos_q} : 64'd0;
          if (into >= {48'b0, fade_len_q}) begin
            fading_q     = 1'b0;
            res.gain     = '0;
            res.fade_end = 1'b1;
          end else begin
            res.gain     = curve_gain((into << PHASE_BITS) / {48'b0, fade_len_q});
            res.fade_end = 1'b0;
          end
          gain_due_q.push_back(res);
        end
      end
      OP_TRACK: begin
        fading_q    = 1'b0;
        last_pos_q  = '0;
        track_len_q = val;
      end
      default: begin
        track_len_q = val;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gain_result_t want;
    if (!rst_ni) begin
      fade_len_q       = '0;
      enabled_q        = 1'b1;
      fading_q         = 1'b0;
      last_pos_q       = '0;
      start_pos_q      = '0;
      track_len_q      = '0;
      gain_due_q.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      gains_seen_o     = 0;
      fade_ends_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_index_i) == REG_FADE_LENGTH) begin
          fade_len_q = cfg_data_i[FADE_W-1:0];
        end else if (reg_idx_e'(cfg_index_i) == REG_ENABLED) begin
          enabled_q = cfg_data_i[0];
          if (!enabled_q) fading_q = 1'b0;
        end
      end
      // Compare first: a result can never belong to the event accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (fade_end_i) fade_ends_seen_o++;
        else gains_seen_o++;
        if (gain_due_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: unexpected result gain %0d end %0b", $realtime, gain_q15_i,
                     fade_end_i);
        end else begin
          want = gain_due_q.pop_front();
          if (want.gain !== gain_q15_i || want.fade_end !== fade_end_i) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS)
              $display("%0t: result mismatch: expected gain %0d end %0b, got gain %0d end %0b",
                       $realtime, want.gain, want.fade_end, gain_q15_i, fade_end_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_event(op_e'(operation_i), value_ms_i);
      pending_o = gain_due_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the fade-out gain testbench: clock, reset, register writes and event stimulus.
// Instantiates equal_power_fade_out_gain_unit and equal_power_fade_out_gain_checker.
`timescale 1ns / 100ps

module testbench;
  import epfog_pkg::*;

  localparam int unsigned HALF_PERIOD_NS = 4;
  localparam int unsigned TIMEOUT_NS     = 5_000_000;
  // Extra wait after the owed results are drained, before touching registers.
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned PHASE_COUNT    = 10;
  localparam int unsigned ACTIVE_ITEMS   = 48;
  localparam int unsigned MUTED_ITEMS    = 25;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       operation;
  logic [POS_W-1:0]      value_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [GAIN_W-1:0]     gain_q15;
  logic                  fade_end;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned gain_count;
  int unsigned fade_end_count;

  // Stimulus bookkeeping
  int unsigned events_sent;
  int unsigned reg_writes;
  int unsigned burst_left;
  logic [FADE_W-1:0] fade_len;

  equal_power_fade_out_gain_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .value_ms_i  (value_ms),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .gain_q15_o  (gain_q15),
    .fade_end_o  (fade_end)
  );

  equal_power_fade_out_gain_checker gain_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .value_ms_i       (value_ms),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .gain_q15_i       (gain_q15),
    .fade_end_i       (fade_end),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .gains_seen_o     (gain_count),
    .fade_ends_seen_o (fade_end_count)
  );

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD_NS) clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: pick a stall mode for a random stretch of cycles, then switch.
  initial begin
    int unsigned mode;
    int unsigned left;
    out_ready = 1'b0;
    mode      = 0;
    left      = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((left % 9) < 3);
      endcase
    end
  end

  // Every stimulus task starts before a falling edge and drives only on falling edges.
  // post_event returns right after the rising edge that accepted its transaction.
  task automatic post_event(input op_e op, input logic [POS_W-1:0] val);
    int unsigned gap;
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) begin
      // hold off until the unit has drained every result owed
      in_valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
    end else if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap        = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    value_ms  <= val;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  // Drop valid and let the unit go idle before a register write.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FADE_LENGTH) fade_len = data;
    reg_writes++;
  endtask

  // One well-formed fade: new track, arm near the end, tick while advancing, finish.
  task automatic play_fade();
    logic [POS_W-1:0] track_ms;
    logic [POS_W-1:0] start;
    int unsigned      span;
    int unsigned      moved;
    span  = (fade_len != 0) ? fade_len : $urandom_range(1, 500);
    moved = 0;
    if ($urandom_range(0, 3) == 0) track_ms = POS_W'($urandom_range(span, 32'h7FFF_FFFF));
    else track_ms = POS_W'(span + $urandom_range(1, 3000));
    if ($urandom_range(0, 3) == 0) post_event(OP_DURATION, track_ms);
    else post_event(OP_TRACK, track_ms);
    if ($urandom_range(0, 1) == 0) post_event(OP_POSITION, POS_W'(track_ms - span - 1));
    case ($urandom_range(0, 5))
      0:       start = POS_W'(track_ms - span);
      1:       start = track_ms - 1'b1;
      default: start = POS_W'(track_ms - $urandom_range(1, span));
    endcase
    post_event(OP_POSITION, start);
    for (int k = 0; k < 12 && moved < span; k++) begin
      post_event(OP_TICK, POS_W'($urandom));
      case ($urandom_range(0, 7))
        0: post_event(OP_POSITION, POS_W'(start - $urandom_range(0, 50)));
        1: post_event(OP_DURATION, POS_W'($urandom));
        default: begin
          moved += $urandom_range(1, span / 4 + 1);
          post_event(OP_POSITION, POS_W'(start + moved));
        end
      endcase
    end
    post_event(OP_POSITION, POS_W'(start + span + $urandom_range(0, 2)));
    post_event(OP_TICK, POS_W'($urandom));
    if ($urandom_range(0, 2) == 0) post_event(OP_TICK, POS_W'($urandom));
  endtask

  // Stray event with a value from the edges or from the full range.
  task automatic post_noise();
    logic [POS_W-1:0] val;
    case ($urandom_range(0, 3))
      0:       val = POS_W'($urandom);
      1:       val = '0;
      2:       val = '1;
      default: val = POS_W'($urandom_range(0, 100000));
    endcase
    post_event(op_e'($urandom_range(0, 3)), val);
  endtask

  initial begin
    int unsigned target;
    logic        enable;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    operation   = '0;
    value_ms    = '0;
    events_sent = 0;
    reg_writes  = 0;
    burst_left  = 0;
    fade_len    = '0;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: window edges, a 100 ms fade walked to its end, clears and mid-fade updates.
    write_reg(REG_FADE_LENGTH, 16'd100);
    write_reg(REG_ENABLED, 16'd1);
    post_event(OP_TICK, '1);                  // nothing armed yet
    post_event(OP_POSITION, 31'd5);           // no duration known
    post_event(OP_DURATION, '1);
    post_event(OP_TRACK, 31'd1000);
    post_event(OP_POSITION, 31'd899);         // one past the window
    post_event(OP_POSITION, 31'd1000);        // nothing remaining
    post_event(OP_POSITION, 31'd1500);        // past the end
    post_event(OP_POSITION, 31'd900);         // exactly the fade length left: arm
    post_event(OP_TICK, '0);
    post_event(OP_POSITION, 31'd950);
    post_event(OP_TICK, 31'h2AAA_AAAA);
    post_event(OP_POSITION, 31'd800);         // behind the fade start: full gain
    post_event(OP_TICK, 31'h5555_5555);
    post_event(OP_DURATION, '0);              // duration drops while fading
    post_event(OP_POSITION, 31'd999);
    post_event(OP_TICK, '0);
    post_event(OP_POSITION, 31'd1000);
    post_event(OP_TICK, '0);                  // fade finished
    post_event(OP_TRACK, '1);
    post_event(OP_POSITION, 31'h7FFF_FFFE);   // one ms left on the longest track
    post_event(OP_TICK, '0);
    post_event(OP_TRACK, 31'd5);              // track change disarms
    post_event(OP_TICK, '0);
    post_event(OP_POSITION, 31'd4);           // arm again, then drop it by disabling
    settle();
    write_reg(REG_ENABLED, 16'd0);
    write_reg(REG_ENABLED, 16'd1);
    post_event(OP_TICK, '0);

    // Random phases over a range of fade lengths, two of them with the unit disabled.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0:       write_reg(REG_FADE_LENGTH, 16'd1);
        1:       write_reg(REG_FADE_LENGTH, 16'hFFFF);
        2:       write_reg(REG_FADE_LENGTH, 16'd0);
        3:       write_reg(REG_FADE_LENGTH, 16'd300);
        4:       write_reg(REG_FADE_LENGTH, 16'd7);
        5:       write_reg(REG_FADE_LENGTH, CFG_DATA_W'($urandom_range(2, 65534)));
        6:       write_reg(REG_FADE_LENGTH, 16'd1000);
        7:       write_reg(REG_FADE_LENGTH, 16'hFFFF);
        8:       write_reg(REG_FADE_LENGTH, 16'd2);
        default: write_reg(REG_FADE_LENGTH, CFG_DATA_W'($urandom_range(1, 300)));
      endcase
      enable = !(phase == 3 || phase == 7);
      // upper data bits are don't-care for the enable register; toggle them anyway
      write_reg(REG_ENABLED, {15'($urandom), enable});
      target = events_sent + (enable ? ACTIVE_ITEMS : MUTED_ITEMS);
      while (events_sent < target) begin
        if ($urandom_range(0, 4) == 0) post_noise();
        else play_fade();
      end
    end

    settle();
    $display("Sent %0d events across %0d register writes over %0d phases",
             events_sent, reg_writes, PHASE_COUNT);
    $display("Received %0d fade gains and %0d fade ends", gain_count, fade_end_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
